/* src/vectored_interrupt_controller_unit_assert.svh */
`ifndef VECTORED_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH
`define VECTORED_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH

// Assertion helpers, active outside synthesis only.
`ifndef SYNTHESIS
`define VIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vic assertion failed");
`define VIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vic assertion failed");
`else
`define VIC_ASSERT(lbl, clk, rstn, prop)
`define VIC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* src/vic_pkg.sv */
package vic_pkg;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [5:0] REG_IRQ_STATUS = 6'd0;
  localparam logic [5:0] REG_FIQ_STATUS = 6'd1;
  localparam logic [5:0] REG_RAW        = 6'd2;
  localparam logic [5:0] REG_SELECT     = 6'd3;
  localparam logic [5:0] REG_ENABLE     = 6'd4;
  localparam logic [5:0] REG_CLEAR      = 6'd5;
  localparam logic [5:0] REG_VECTOR     = 6'd6;
  localparam logic [5:0] REG_DEFAULT    = 6'd7;

  localparam int CtrlWidth     = 6;
  localparam int CtrlEnableBit = 5;

  typedef logic [CtrlWidth-1:0] ctrl_t;

endpackage

/* src/vectored_interrupt_controller_unit.sv */
// Channel  | Handshake                  | Payload
// input    | in_valid_i / in_stall_o    | mode_i, reg_address_i, write_data_i, source_lines_i
// output   | out_valid_o / out_stall_i  | read_data_o, irq_request_o, fiq_request_o
// An item goes through accept, vector memory read and result shown, in that order.
// The vector address memory has one read port, and its read data is registered.
// The result stays in the output register until taken; no item is accepted meanwhile.
// Reset clears state, control and output regs and slot valid bits; no clearing pass needed.
`include "vectored_interrupt_controller_unit_assert.svh"

module vectored_interrupt_controller_unit
  import vic_pkg::*;
#(
  parameter int NUM_SOURCES = 32,
  parameter int NUM_SLOTS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  reg_address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] source_lines_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_request_o,
  output logic        fiq_request_o
);

  localparam int SW = $clog2(NUM_SLOTS);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_OUT} state_e;

  state_e state_q;

  logic [NUM_SOURCES-1:0] sel_q, en_q, raw_q;
  logic [31:0]            default_q;
  ctrl_t                  ctrl_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   valid_q;
  logic [NUM_SLOTS:0]     isv_q, isv_d;
  logic [31:0]            addr_mem [NUM_SLOTS];
  logic [31:0]            mem_rdata_q;
  logic [SW-1:0]          rd_idx;
  logic                   mem_re;
  logic                   from_mem_q, hit_q;
  logic [31:0]            rd_q, rd_d;

  logic                   accept;
  logic [NUM_SOURCES-1:0] raw, irq_st, fiq_st;
  logic                   is_wr, is_rd;
  logic                   a_win, c_win;
  logic [4:0]             a_k, c_k;
  logic                   found;
  logic [SW-1:0]          win;
  logic [31:0]            rd_val;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign raw    = source_lines_i[NUM_SOURCES-1:0];
  assign irq_st = raw & en_q & ~sel_q;
  assign fiq_st = raw & en_q & sel_q;
  assign is_wr  = accept && (mode_i == MODE_WRITE);
  assign is_rd  = accept && (mode_i == MODE_READ);
  assign a_k    = {1'b0, reg_address_i[3:0]};
  assign c_k    = reg_address_i[4:0];
  assign a_win  = (reg_address_i[5:4] == 2'b01) && (32'(a_k) < 32'(NUM_SLOTS));
  assign c_win  = reg_address_i[5] && (32'(c_k) < 32'(NUM_SLOTS));

  vic_prio #(.NUM_SLOTS(NUM_SLOTS)) u_prio (
    .ctrl_i       (ctrl_q),
    .in_service_i (isv_q),
    .pending_i    (32'(irq_st)),
    .found_o      (found),
    .win_o        (win)
  );

  always_comb begin
    isv_d  = isv_q;
    rd_d   = '0;
    mem_re = 1'b0;
    rd_idx = a_k[SW-1:0];
    if (is_wr && reg_address_i == REG_VECTOR) begin
      isv_d = isv_q & (isv_q - 1'b1);
    end
    if (is_rd) begin
      priority if (reg_address_i == REG_IRQ_STATUS) begin
        rd_d = 32'(irq_st);
      end else if (reg_address_i == REG_FIQ_STATUS) begin
        rd_d = 32'(fiq_st);
      end else if (reg_address_i == REG_RAW) begin
        rd_d = 32'(raw);
      end else if (reg_address_i == REG_SELECT) begin
        rd_d = 32'(sel_q);
      end else if (reg_address_i == REG_ENABLE) begin
        rd_d = 32'(en_q);
      end else if (reg_address_i == REG_VECTOR) begin
        if (found) begin
          mem_re = 1'b1;
          rd_idx = win;
          isv_d  = isv_q | ((NUM_SLOTS+1)'(1) << win);
        end else begin
          rd_d  = default_q;
          isv_d = isv_q | ((NUM_SLOTS+1)'(1) << NUM_SLOTS);
        end
      end else if (reg_address_i == REG_DEFAULT) begin
        rd_d = default_q;
      end else if (a_win) begin
        mem_re = 1'b1;
      end else if (c_win) begin
        rd_d = 32'(ctrl_q[c_k[SW-1:0]]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_wr && a_win) begin
      addr_mem[a_k[SW-1:0]] <= write_data_i;
    end
    if (mem_re) begin
      mem_rdata_q <= addr_mem[rd_idx];
    end
    if (accept) begin
      rd_q       <= rd_d;
      from_mem_q <= mem_re;
      hit_q      <= valid_q[rd_idx];
      raw_q      <= raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= '0;
      en_q      <= '0;
      default_q <= '0;
      valid_q   <= '0;
      isv_q     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) ctrl_q[i] <= '0;
    end else begin
      isv_q <= isv_d;
      if (is_wr) begin
        priority if (reg_address_i == REG_SELECT) begin
          sel_q <= write_data_i[NUM_SOURCES-1:0];
        end else if (reg_address_i == REG_ENABLE) begin
          en_q <= en_q | write_data_i[NUM_SOURCES-1:0];
        end else if (reg_address_i == REG_CLEAR) begin
          en_q <= en_q & ~write_data_i[NUM_SOURCES-1:0];
        end else if (reg_address_i == REG_DEFAULT) begin
          default_q <= write_data_i;
        end else if (a_win) begin
          valid_q[a_k[SW-1:0]] <= 1'b1;
        end else if (c_win) begin
          ctrl_q[c_k[SW-1:0]] <= write_data_i[CtrlWidth-1:0];
        end
      end
    end
  end

  assign rd_val = from_mem_q ? (hit_q ? mem_rdata_q : '0) : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_o   <= 1'b0;
      read_data_o   <= '0;
      irq_request_o <= 1'b0;
      fiq_request_o <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          out_valid_o   <= 1'b1;
          read_data_o   <= rd_val;
          irq_request_o <= |(raw_q & en_q & ~sel_q);
          fiq_request_o <= |(raw_q & en_q & sel_q);
          state_q       <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `VIC_ASSERT(a_out_in_out_state, clk_i, rst_ni, out_valid_o |-> state_q == ST_OUT)
  `VIC_ASSERT(a_stall_busy, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  `VIC_ASSERT(a_vec_read_marks, clk_i, rst_ni,
    (is_rd && reg_address_i == REG_VECTOR) |=> isv_q != '0)
  `VIC_ASSERT(a_fetch_follows_accept, clk_i, rst_ni, accept |=> state_q == ST_FETCH)

endmodule

/* src/vic_prio.sv */
module vic_prio
  import vic_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  ctrl_t                          ctrl_i [NUM_SLOTS],
  input  logic  [NUM_SLOTS:0]            in_service_i,
  input  logic  [31:0]                   pending_i,
  output logic                           found_o,
  output logic  [$clog2(NUM_SLOTS)-1:0]  win_o
);

  always_comb begin
    logic blocked;
    blocked = 1'b0;
    found_o = 1'b0;
    win_o   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      blocked = blocked | in_service_i[i];
      if (!found_o && !blocked && ctrl_i[i][CtrlEnableBit] &&
          pending_i[ctrl_i[i][4:0]]) begin
        found_o = 1'b1;
        win_o   = ($clog2(NUM_SLOTS))'(i);
      end
    end
  end

endmodule

/* tb/sv/vic_checker.sv */
`timescale 1ns / 100ps

module vic_checker
  import vic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  reg_address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] source_lines_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] read_data_o,
  input  logic        irq_request_o,
  input  logic        fiq_request_o,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NumSlots = 16;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        fiq;
  } vic_result_t;

  logic [31:0]       fast_mask;
  logic [31:0]       line_enable;
  logic [31:0]       default_vec;
  logic [31:0]       slot_vec [NumSlots];
  ctrl_t             slot_ctrl [NumSlots];
  logic [NumSlots:0] serving;
  vic_result_t       expected_q [$];

  function automatic int top_rank();
    for (int i = 0; i <= NumSlots; i++) begin
      if (serving[i]) return i;
    end
    return NumSlots + 1;
  endfunction

  function automatic vic_result_t model_access(logic [1:0] mode, logic [5:0] addr,
                                               logic [31:0] data, logic [31:0] raw);
    vic_result_t r;
    logic [31:0] irq_st;
    int          lvl;
    int          k;
    bit          hit;
    irq_st = raw & line_enable & ~fast_mask;
    r = '0;
    k = int'(addr) & 15;
    if (mode == MODE_WRITE) begin
      if (addr == REG_SELECT) fast_mask = data;
      else if (addr == REG_ENABLE) line_enable |= data;
      else if (addr == REG_CLEAR) line_enable &= ~data;
      else if (addr == REG_VECTOR) begin
        lvl = top_rank();
        if (lvl <= NumSlots) serving[lvl] = 1'b0;
      end else if (addr == REG_DEFAULT) default_vec = data;
      else if (addr >= 16 && addr < 32) slot_vec[k] = data;
      else if (addr >= 32 && addr < 48) slot_ctrl[k] = data[CtrlWidth-1:0];
    end else if (mode == MODE_READ) begin
      if (addr == REG_IRQ_STATUS) r.read_data = irq_st;
      else if (addr == REG_FIQ_STATUS) r.read_data = raw & line_enable & fast_mask;
      else if (addr == REG_RAW) r.read_data = raw;
      else if (addr == REG_SELECT) r.read_data = fast_mask;
      else if (addr == REG_ENABLE) r.read_data = line_enable;
      else if (addr == REG_VECTOR) begin
        lvl = top_rank();
        hit = 0;
        for (int i = 0; i < NumSlots; i++) begin
          if (!hit && i < lvl && slot_ctrl[i][CtrlEnableBit] &&
              irq_st[slot_ctrl[i][4:0]]) begin
            hit = 1;
            serving[i] = 1'b1;
            r.read_data = slot_vec[i];
          end
        end
        if (!hit) begin
          serving[NumSlots] = 1'b1;
          r.read_data = default_vec;
        end
      end else if (addr == REG_DEFAULT) r.read_data = default_vec;
      else if (addr >= 16 && addr < 32) r.read_data = slot_vec[k];
      else if (addr >= 32 && addr < 48) r.read_data = 32'(slot_ctrl[k]);
    end
    r.irq = |(raw & line_enable & ~fast_mask);
    r.fiq = |(raw & line_enable & fast_mask);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vic_result_t exp_r;
    if (!rst_ni) begin
      fast_mask    = '0;
      line_enable  = '0;
      default_vec  = '0;
      serving      = '0;
      fail_count_o <= 0;
      for (int i = 0; i < NumSlots; i++) begin
        slot_vec[i]  = '0;
        slot_ctrl[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(model_access(mode_i, reg_address_i, write_data_i,
                                          source_lines_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result rd=%h irq=%b fiq=%b", $time,
                   read_data_o, irq_request_o, fiq_request_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.read_data !== read_data_o || exp_r.irq !== irq_request_o ||
              exp_r.fiq !== fiq_request_o) begin
            $display("%0t: mismatch expected rd=%h irq=%b fiq=%b actual rd=%h irq=%b fiq=%b",
                     $time, exp_r.read_data, exp_r.irq, exp_r.fiq,
                     read_data_o, irq_request_o, fiq_request_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_vectored_interrupt_controller_unit.sv */
`timescale 1ns / 100ps

module tb_vectored_interrupt_controller_unit;
  import vic_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = MODE_NONE;
  logic [5:0]  reg_address_i = '0;
  logic [31:0] write_data_i = '0;
  logic [31:0] source_lines_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic        irq_request_o;
  logic        fiq_request_o;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          inputs_done = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vectored_interrupt_controller_unit DUT (.*);

  vic_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  task automatic send_access(logic [1:0] mode, logic [5:0] addr, logic [31:0] data,
                             logic [31:0] lines);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    reg_address_i  <= addr;
    write_data_i   <= data;
    source_lines_i <= lines;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_lines();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_access();
    logic [1:0]  mode;
    logic [5:0]  addr;
    logic [31:0] data;
    int          pick;
    pick = $urandom_range(0, 99);
    mode = (pick < 45) ? MODE_READ : (pick < 85) ? MODE_WRITE
         : (pick < 95) ? MODE_NONE : 2'd3;
    case ($urandom_range(0, 9))
      0, 1, 2: addr = REG_VECTOR;
      3: addr = 6'($urandom_range(0, 7));
      4: addr = 6'($urandom_range(0, 63));
      5, 6: addr = 6'($urandom_range(16, 31));
      7, 8: addr = 6'($urandom_range(32, 47));
      default: addr = ($urandom_range(0, 1) != 0) ? REG_ENABLE : REG_CLEAR;
    endcase
    data = $urandom();
    if (addr >= 32 && $urandom_range(0, 1) != 0) data[5] = 1'b1;
    send_access(mode, addr, data, rand_lines());
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    send_access(MODE_READ, REG_VECTOR, '0, '1);
    send_access(MODE_WRITE, REG_VECTOR, '0, '0);
    send_access(MODE_WRITE, REG_VECTOR, '0, '0);
    send_access(MODE_WRITE, REG_ENABLE, '1, '1);
    send_access(MODE_WRITE, REG_SELECT, 32'hffff0000, '1);
    send_access(MODE_WRITE, REG_DEFAULT, '1, '0);
    send_access(MODE_WRITE, 6'd16, 32'h12345678, '0);
    send_access(MODE_WRITE, 6'd31, '1, '0);
    send_access(MODE_WRITE, 6'd32, 32'hffffffe0, '0);
    send_access(MODE_WRITE, 6'd47, 32'h0000003f, '0);
    send_access(MODE_WRITE, 6'd8, '1, '1);
    send_access(MODE_READ, 6'd15, '0, '1);
    send_access(MODE_READ, 6'd63, '0, '1);
    send_access(MODE_READ, REG_CLEAR, '0, '1);
    send_access(2'd3, REG_DEFAULT, '0, '1);
    for (int a = 0; a < 8; a++) send_access(MODE_READ, 6'(a), '0, $urandom());
    send_access(MODE_READ, REG_VECTOR, '0, 32'h00000001);
    send_access(MODE_WRITE, REG_CLEAR, '1, '1);
    for (int n = 0; n < 1250; n++) begin
      if (n == 600) begin
        in_valid_i <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
      random_access();
    end
    in_valid_i <= 1'b0;
    inputs_done = 1;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (inputs_done && pending == 0) begin
        repeat (10) @(posedge clk_i);
        if (fail_count == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
      end else if (idle_cycles >= 2000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
